[rtl/core/sme_pkg.sv]
// shared types and constants for the stack machine execute unit
// no dependencies
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = SP_W + 1;
    localparam int NUM_VARS    = 16;
    localparam int VAR_W       = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    typedef enum logic [3:0] {
        F_PUSH = 4'd0, F_ADD = 4'd1, F_SUB = 4'd2, F_MUL = 4'd3,
        F_DIV = 4'd4, F_MOD = 4'd5, F_AND = 4'd6, F_OR = 4'd7,
        F_XOR = 4'd8, F_STORE = 4'd9, F_LOAD = 4'd10, F_JZ = 4'd11,
        F_JMP = 4'd12, F_PUSHEXT = 4'd13, F_POPEMIT = 4'd14, F_HALT = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_HALT = 2'd1, ST_UNDER = 2'd2, ST_OVER = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DIV, S_WRITE, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input transaction
        logic rd_issue;    // read stack top two entries
        logic div_start;
        logic commit;      // write back, form result
        logic out_take;    // result accepted downstream
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_div;
        logic div_done;
    } t_sts;

    localparam logic [0:0] REG_STACK_LIMIT = 1'd0;

endpackage

[rtl/core/sme_div.sv]
// iterative signed divider, one quotient bit per cycle
// depends on sme_pkg
module sme_div import sme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic [31:0] r_q, r_r, r_d;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done, r_nq, r_nr;
    logic [32:0] w_trial;

    assign w_trial = {r_r, r_q[31]} - {1'b0, r_d};

    // restoring division on magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_d    <= i_b[31] ? (32'd0 - i_b) : i_b;
                r_r    <= 32'd0;
                r_nq   <= i_a[31] ^ i_b[31];
                r_nr   <= i_a[31];
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_r <= w_trial[31:0];
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= {r_r[30:0], r_q[31]};
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq ? (32'd0 - r_q) : r_q;
    assign o_rem  = r_nr ? (32'd0 - r_r) : r_r;
endmodule

[rtl/core/sme_datapath.sv]
// stack memory, variables, alu and result register
// depends on sme_pkg, sme_div
module sme_datapath import sme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [6:0]  i_limit,
    input  logic [3:0]  i_func,
    input  logic [7:0]  i_imm,
    input  logic [15:0] i_fall,
    input  logic [31:0] i_ext,
    output logic [89:0] o_res
);
    logic [31:0]      r_mem [STACK_DEPTH];
    logic [31:0]      r_vars [NUM_VARS];
    logic [CNT_W-1:0] r_depth;
    logic [31:0]      r_b, r_a;
    t_func            r_func;
    logic [7:0]       r_imm;
    logic [15:0]      r_fall;
    logic [31:0]      r_ext;
    logic [89:0]      r_res;

    logic [SP_W-1:0]  w_ia, w_ib;
    logic             w_div_done;
    logic [31:0]      w_q, w_r;

    assign w_ib = SP_W'(r_depth - CNT_W'(1));
    assign w_ia = SP_W'(r_depth - CNT_W'(2));

    sme_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_a(r_a), .i_b(r_b), .o_done(w_div_done), .o_quot(w_q), .o_rem(w_r)
    );

    assign o_sts.is_div   = (r_func == F_DIV) || (r_func == F_MOD);
    assign o_sts.div_done = w_div_done;

    // commit logic
    logic [CNT_W-1:0] c_depth;
    logic             c_we;
    logic [SP_W-1:0]  c_wa;
    logic [31:0]      c_wd, c_alu, c_pv, c_top, c_emv;
    logic             c_vwe, c_push, c_emit, c_idx_ok, c_ovf;
    t_status          c_st;
    logic [15:0]      c_next;
    logic [CNT_W:0]   c_lim;

    always_comb begin
        c_idx_ok = ({8'd0} | r_imm) < 8'(NUM_VARS);
        c_depth = r_depth;
        c_we = 1'b0; c_wa = w_ia; c_wd = 32'd0; c_vwe = 1'b0;
        c_st = ST_OK; c_next = r_fall; c_push = 1'b0; c_pv = 32'd0;
        c_emit = 1'b0; c_emv = 32'd0;
        c_lim = ({1'b0, i_limit} < (CNT_W+1)'(STACK_DEPTH)) ?
                (CNT_W+1)'(i_limit) : (CNT_W+1)'(STACK_DEPTH);
        case (r_func)
            F_ADD: c_alu = r_a + r_b;
            F_SUB: c_alu = r_a - r_b;
            F_MUL: c_alu = r_a * r_b;
            F_DIV: c_alu = (r_b == 32'd0) ? 32'd0 :
                   (r_a == 32'h8000_0000 && r_b == '1) ? 32'h8000_0000 : w_q;
            F_MOD: c_alu = (r_b == 32'd0 || (r_a == 32'h8000_0000 && r_b == '1))
                   ? 32'd0 : w_r;
            F_AND: c_alu = r_a & r_b;
            F_OR:  c_alu = r_a | r_b;
            default: c_alu = r_a ^ r_b;
        endcase
        case (r_func)
            F_PUSH:    begin c_push = 1'b1; c_pv = {24'd0, r_imm}; end
            F_PUSHEXT: begin c_push = 1'b1; c_pv = r_ext; end
            F_LOAD: begin
                c_push = 1'b1;
                c_pv = c_idx_ok ? r_vars[VAR_W'(r_imm)] : 32'd0;
            end
            F_ADD, F_SUB, F_MUL, F_DIV, F_MOD, F_AND, F_OR, F_XOR: begin
                if (r_depth < CNT_W'(2)) c_st = ST_UNDER;
                else begin
                    c_we = 1'b1; c_wa = w_ia; c_wd = c_alu;
                    c_depth = r_depth - CNT_W'(1);
                end
            end
            F_STORE: begin
                if (c_idx_ok) begin
                    if (r_depth == '0) c_st = ST_UNDER;
                    else begin
                        c_vwe = 1'b1;
                        c_depth = r_depth - CNT_W'(1);
                    end
                end
            end
            F_JZ: begin
                if (r_depth == '0) c_st = ST_UNDER;
                else begin
                    c_depth = r_depth - CNT_W'(1);
                    if (r_b == 32'd0) c_next = r_fall + {{8{r_imm[7]}}, r_imm};
                end
            end
            F_JMP: c_next = r_fall + {{8{r_imm[7]}}, r_imm};
            F_POPEMIT: begin
                if (r_depth == '0) c_st = ST_UNDER;
                else begin
                    c_depth = r_depth - CNT_W'(1);
                    c_emit = 1'b1; c_emv = r_b;
                end
            end
            default: c_st = ST_HALT;
        endcase
        c_ovf = {1'b0, r_depth} >= c_lim;
        if (c_push) begin
            if (c_ovf) c_st = ST_OVER;
            else begin
                c_we = 1'b1; c_wa = SP_W'(r_depth); c_wd = c_pv;
                c_depth = r_depth + CNT_W'(1);
            end
        end
        // new top: written value, else entry below b (held in r_a), else unchanged; zero when empty
        if (c_we) c_top = c_wd;
        else if (c_depth != r_depth) c_top = r_a;
        else c_top = r_b;
        if (c_depth == '0) c_top = 32'd0;
    end

    // capture, stack reads, commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= t_func'(i_func);
            r_imm  <= i_imm;
            r_fall <= i_fall;
            r_ext  <= i_ext;
        end
        if (i_cmd.rd_issue) begin
            r_b <= r_mem[w_ib];
            r_a <= r_mem[w_ia];
        end
        if (c_we && i_cmd.commit) r_mem[c_wa] <= c_wd;
        if (i_cmd.commit) begin
            r_res <= {c_emv, c_emit, 7'(c_depth), c_top, c_next, c_st};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            for (int k = 0; k < NUM_VARS; k++) r_vars[k] <= 32'd0;
        end else if (i_cmd.commit) begin
            r_depth <= c_depth;
            if (c_vwe) r_vars[VAR_W'(r_imm)] <= r_b;
        end
    end

    assign o_res = r_res;
    logic w_unused;
    assign w_unused = i_cmd.out_take;
endmodule

[rtl/core/sme_ctrl.sv]
// controller state machine sequencing read, divide, write-back and output
// depends on sme_pkg
module sme_ctrl import sme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                o_cmd.out_take = i_out_ready;
                if (i_out_ready) begin
                    o_cmd.load_item = i_in_valid;
                    n_state = i_in_valid ? S_READ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/core/stack_machine_execute_unit.sv]
// top level of the stack machine execute unit
// depends on sme_pkg, sme_ctrl, sme_datapath, sme_div
//
// usage:
//   slave stream s_axis carries one decoded instruction per transaction;
//   master stream m_axis returns one result per instruction, in order.
//   apb port holds stack_limit at address 0 (reset 64).
// sequencing:
//   the result is formed in two steps once an instruction is accepted:
//   the read state fetches the top two stack entries from the stack memory,
//   then the write state computes and writes back. div and mod start the
//   32-step iterative divider in the write state and write back when done.
//   a new instruction is taken in the cycle its predecessor's result is
//   accepted and not before, so one instruction is in flight at a time.
// reset:
//   synchronous active low; clears stack depth and variables, limit to 64.
// stall:
//   while m_axis_tready is low the result holds and no new item is taken.
module stack_machine_execute_unit import sme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[3:0], immediate[11:4], fall_through_addr[27:12], external_value[59:28]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], next_addr[17:2], top_value[49:18], stack_count[56:50],
    // emit_valid[57], emit_value[89:58]
    output logic [95:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [6:0]  r_limit;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [89:0] w_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 7'd64;
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
            r_limit <= pwdata[6:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, r_limit} : 32'd0;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    sme_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_limit(r_limit),
        .i_func(s_axis_tdata[3:0]), .i_imm(s_axis_tdata[11:4]),
        .i_fall(s_axis_tdata[27:12]), .i_ext(s_axis_tdata[59:28]),
        .o_res(w_res)
    );

    // tdata: upper unused bits zero
    assign m_axis_tdata = {6'd0, w_res};

    logic w_unused;
    assign w_unused = ^s_axis_tdata[63:60] ^ ^pwdata[31:7];
endmodule
